@@ sv/sma_pkg.sv @@
// shared types and constants for the stack machine arithmetic unit
`timescale 1ns / 1ps

package sma_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int WORD_WIDTH_DEF  = 32;
    localparam int MODE_W          = 3;
    localparam int STATUS_W        = 2;

    // request operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH = 3'd0,
        MODE_ADD  = 3'd1,
        MODE_SUB  = 3'd2,
        MODE_MUL  = 3'd3,
        MODE_DIV  = 3'd4,
        MODE_MOD  = 3'd5
    } mode_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_DIV_ZERO  = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    // main sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_EXEC
    } ctrl_state_t;

    // arithmetic unit states
    typedef enum logic [1:0] {
        U_IDLE,
        U_LOOP,
        U_FIX
    } unit_state_t;

    // operation launch from the sequencer to the arithmetic unit
    typedef struct packed {
        logic  start;
        mode_t op;
    } unit_req_t;

endpackage

@@ sv/sma_stack_mem.sv @@
// operand stack storage: one write port, one registered read port
`timescale 1ns / 1ps

module sma_stack_mem
    import sma_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int WORD_WIDTH  = WORD_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
    input  logic [WORD_WIDTH-1:0]          wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
    output logic [WORD_WIDTH-1:0]          rd_data
);

    logic [WORD_WIDTH-1:0] stack_mem [STACK_DEPTH];
    logic [WORD_WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/sma_arith_unit.sv @@
// arithmetic unit: add/sub computed directly from the request, bit-serial multiply and signed divide/remainder
`timescale 1ns / 1ps

module sma_arith_unit
    import sma_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  unit_req_t             req,
    input  logic [WORD_WIDTH-1:0] a,
    input  logic [WORD_WIDTH-1:0] b,
    output logic                  done,
    output logic [WORD_WIDTH-1:0] result
);

    localparam int CNT_W = $clog2(WORD_WIDTH);

    unit_state_t           state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    mode_t                 op_reg, op_next;
    logic [WORD_WIDTH:0]   acc_reg, acc_next;
    logic [WORD_WIDTH-1:0] sh_reg, sh_next;
    logic [WORD_WIDTH-1:0] opnd_reg, opnd_next;
    logic                  neg_q_reg, neg_q_next;
    logic                  neg_r_reg, neg_r_next;
    logic [WORD_WIDTH-1:0] result_reg, result_next;
    logic                  done_reg, done_next;

    logic [WORD_WIDTH-1:0] mag_a, mag_b;
    logic [WORD_WIDTH:0]   rem_shift, diff;

    // operand magnitudes for the divider
    assign mag_a = a[WORD_WIDTH-1] ? (~a + 1'b1) : a;
    assign mag_b = b[WORD_WIDTH-1] ? (~b + 1'b1) : b;

    // restoring divide step: shift in next dividend bit, trial subtract
    assign rem_shift = {acc_reg[WORD_WIDTH-1:0], sh_reg[WORD_WIDTH-1]};
    assign diff      = rem_shift - {1'b0, opnd_reg};

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        op_reg     <= op_next;
        acc_reg    <= acc_next;
        sh_reg     <= sh_next;
        opnd_reg   <= opnd_next;
        neg_q_reg  <= neg_q_next;
        neg_r_reg  <= neg_r_next;
        result_reg <= result_next;
    end

    // next state and datapath
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        acc_next    = acc_reg;
        sh_next     = sh_reg;
        opnd_next   = opnd_reg;
        neg_q_next  = neg_q_reg;
        neg_r_next  = neg_r_reg;
        result_next = result_reg;
        done_next   = 1'b0;

        unique case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    cnt_next = CNT_W'(WORD_WIDTH - 1);
                    acc_next = '0;
                    priority if (req.op == MODE_ADD)
                    begin
                        result_next = a + b;
                        done_next   = 1'b1;
                    end
                    else if (req.op == MODE_SUB)
                    begin
                        result_next = a - b;
                        done_next   = 1'b1;
                    end
                    else if (req.op == MODE_MUL)
                    begin
                        sh_next    = b;
                        opnd_next  = a;
                        state_next = U_LOOP;
                    end
                    else
                    begin
                        sh_next    = mag_a;
                        opnd_next  = mag_b;
                        neg_q_next = a[WORD_WIDTH-1] ^ b[WORD_WIDTH-1];
                        neg_r_next = a[WORD_WIDTH-1];
                        state_next = U_LOOP;
                    end
                end
            end

            U_LOOP:
            begin
                if (op_reg == MODE_MUL)
                begin
                    // shift-add, low word of the product only
                    if (sh_reg[0])
                    begin
                        acc_next = acc_reg + {1'b0, opnd_reg};
                    end
                    opnd_next = {opnd_reg[WORD_WIDTH-2:0], 1'b0};
                    sh_next   = {1'b0, sh_reg[WORD_WIDTH-1:1]};
                end
                else
                begin
                    if (!diff[WORD_WIDTH])
                    begin
                        acc_next = diff;
                        sh_next  = {sh_reg[WORD_WIDTH-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = rem_shift;
                        sh_next  = {sh_reg[WORD_WIDTH-2:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = U_FIX;
                end
            end

            U_FIX:
            begin
                // select result; for divide apply signs: quotient by xor of signs, remainder by dividend
                priority if (op_reg == MODE_MUL)
                begin
                    result_next = acc_reg[WORD_WIDTH-1:0];
                end
                else if (op_reg == MODE_DIV)
                begin
                    result_next = neg_q_reg ? (~sh_reg + 1'b1) : sh_reg;
                end
                else
                begin
                    result_next = neg_r_reg ? (~acc_reg[WORD_WIDTH-1:0] + 1'b1)
                                            : acc_reg[WORD_WIDTH-1:0];
                end
                done_next  = 1'b1;
                state_next = U_IDLE;
            end

            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ sv/stack_machine_arithmetic.sv @@
// stack machine arithmetic unit: top level with request sequencer and top-of-stack register
// push, unknown mode and error requests raise done straight from the decode state; add/sub
//   wait in the execute state for the arithmetic unit, mul/div/mod for its bit-serial loop
// a new request can be taken in the cycle done is high
// reset: rst_n clears the sequencer and the entry count; stack memory holds no reset value
// the receiver cannot stall: done is high for exactly one cycle per result
`timescale 1ns / 1ps

module stack_machine_arithmetic
    import sma_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int WORD_WIDTH  = WORD_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [MODE_W-1:0]                 mode,
    input  logic signed [WORD_WIDTH-1:0]      push_value,
    output logic                              done,
    output logic [STATUS_W-1:0]               status,
    output logic signed [WORD_WIDTH-1:0]      top_value,
    output logic [$clog2(STACK_DEPTH+1)-1:0]  depth
);

    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

    ctrl_state_t           state_reg, state_next;
    logic [DEPTH_W-1:0]    depth_reg, depth_next;
    logic [WORD_WIDTH-1:0] top_reg, top_next;
    mode_t                 mode_reg, mode_next;
    logic [WORD_WIDTH-1:0] value_reg, value_next;
    logic                  done_reg, done_next;
    status_t               out_status_reg, out_status_next;
    logic [WORD_WIDTH-1:0] out_top_reg, out_top_next;
    logic [DEPTH_W-1:0]    out_depth_reg, out_depth_next;

    logic                  wr_en, rd_en;
    logic [ADDR_W-1:0]     wr_addr, rd_addr;
    logic [WORD_WIDTH-1:0] wr_data, rd_data;
    logic [DEPTH_W-1:0]    second_idx;
    logic [WORD_WIDTH-1:0] cur_top;
    logic                  full, few;

    unit_req_t             ureq;
    logic                  u_done;
    logic [WORD_WIDTH-1:0] u_result;

    // stack storage
    sma_stack_mem #(
        .STACK_DEPTH (STACK_DEPTH),
        .WORD_WIDTH  (WORD_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // arithmetic unit: second-from-top from memory, top from register
    sma_arith_unit #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (ureq),
        .a      (rd_data),
        .b      (top_reg),
        .done   (u_done),
        .result (u_result)
    );

    // stack pointer derived values
    assign second_idx = depth_reg - DEPTH_W'(2);
    assign rd_addr    = second_idx[ADDR_W-1:0];
    assign full       = (depth_reg == DEPTH_W'(STACK_DEPTH));
    assign few        = (depth_reg < DEPTH_W'(2));
    assign cur_top    = (depth_reg == '0) ? '0 : top_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            depth_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        mode_reg       <= mode_next;
        value_reg      <= value_next;
        out_status_reg <= out_status_next;
        out_top_reg    <= out_top_next;
        out_depth_reg  <= out_depth_next;
    end

    // sequencer: next state, memory access and result
    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        top_next        = top_reg;
        mode_next       = mode_reg;
        value_next      = value_reg;
        done_next       = 1'b0;
        out_status_next = out_status_reg;
        out_top_next    = out_top_reg;
        out_depth_next  = out_depth_reg;
        wr_en           = 1'b0;
        wr_addr         = rd_addr;
        wr_data         = u_result;
        rd_en           = 1'b0;
        ureq.start      = 1'b0;
        ureq.op         = mode_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next  = mode_t'(mode);
                    value_next = push_value;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next     = S_IDLE;
                done_next      = 1'b1;
                out_status_next = ST_OK;
                out_top_next   = cur_top;
                out_depth_next = depth_reg;
                unique case (mode_reg)
                    MODE_PUSH:
                    begin
                        if (full)
                        begin
                            out_status_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            wr_en          = 1'b1;
                            wr_addr        = depth_reg[ADDR_W-1:0];
                            wr_data        = value_reg;
                            top_next       = value_reg;
                            depth_next     = depth_reg + DEPTH_W'(1);
                            out_top_next   = value_reg;
                            out_depth_next = depth_reg + DEPTH_W'(1);
                        end
                    end

                    MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD:
                    begin
                        // underflow check ahead of the zero divisor check
                        priority if (few)
                        begin
                            out_status_next = ST_UNDERFLOW;
                        end
                        else if ((mode_reg == MODE_DIV || mode_reg == MODE_MOD)
                                 && top_reg == '0)
                        begin
                            out_status_next = ST_DIV_ZERO;
                        end
                        else
                        begin
                            done_next  = 1'b0;
                            rd_en      = 1'b1;
                            state_next = S_READ;
                        end
                    end

                    default:
                    begin
                        out_status_next = ST_OK;
                    end
                endcase
            end

            S_READ:
            begin
                ureq.start = 1'b1;
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                // write back over second-from-top, pop one
                if (u_done)
                begin
                    wr_en           = 1'b1;
                    wr_addr         = rd_addr;
                    wr_data         = u_result;
                    top_next        = u_result;
                    depth_next      = depth_reg - DEPTH_W'(1);
                    done_next       = 1'b1;
                    out_status_next = ST_OK;
                    out_top_next    = u_result;
                    out_depth_next  = depth_reg - DEPTH_W'(1);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = out_status_reg;
    assign top_value = out_top_reg;
    assign depth     = out_depth_reg;

    // one strobe per request, never two in a row
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for more than one cycle");

    // entry count stays within the stack
    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("entry count beyond stack size");

    // overflow only reported on a full stack
    assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_OVERFLOW |-> depth == DEPTH_W'(STACK_DEPTH))
        else $error("overflow status with room on the stack");

    // arithmetic unit completes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n) u_done |-> state_reg == S_EXEC)
        else $error("arithmetic result outside execute state");

    // a taken request makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n) start && !busy |=> busy)
        else $error("request taken without going busy");

endmodule
